// File: rtl/pasm_pkg.sv
`default_nettype none

package pasm_pkg;

   localparam int MAX_TERMS_DEF = 16;

   localparam int COEF_IN_W  = 16;
   localparam int COEF_OUT_W = 32;
   localparam int POWER_W    = 5;
   localparam int POW_LIMIT  = 31;
   // wide enough for count_a + count_b at the largest term count
   localparam int N_W        = 7;

   localparam int OUT_DEPTH = 4;
   localparam int OPTR_W    = 2;
   localparam int OCNT_W    = 3;

   localparam logic [1:0] ACT_LOAD_A = 2'd0;
   localparam logic [1:0] ACT_LOAD_B = 2'd1;
   localparam logic [1:0] ACT_RUN    = 2'd2;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;

   localparam logic [COEF_OUT_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
   localparam logic [COEF_OUT_W-1:0] COEF_MIN = 32'h8000_0000;

   // control that travels with each term read
   typedef struct packed {
      logic               mul;
      logic               sub;
      logic               use_a;
      logic               use_b;
      logic               first;
      logic               last;
      logic               tail;
      logic [POWER_W-1:0] power;
      logic               dropped;
   } tag_type;

   typedef struct packed {
      logic                         dropped;
      logic                         sat;
      logic                         last;
      logic [POWER_W-1:0]           power;
      logic signed [COEF_OUT_W-1:0] coef;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/polynomial_add_sub_mult_top.sv
`default_nettype none

// Channel  Dir  tdata                            tuser                             tlast
// req      in   [15:0] coef_in, [17:16] op       [1:0] action                      last_in
// rsp      out  [31:0] coef_out, [36:32] power   [0] saturated, [1] terms_dropped  last_out
//
// A load word writes one entry of the operand memory; a word beyond MAX_TERMS sets terms_dropped.
// A run issues one read per add or subtract coefficient and one read pair (one MAC) per
// product term, through the single read port of each memory; req_tready is low during a run.
// Results pass stage 1 (memory data and tag) and stage 2 into the result buffer.
// A 4-word result buffer absorbs rsp_tready stalls, and each coefficient's last read waits
// for a free credit. Reset is synchronous; operands reset to zero.

module polynomial_add_sub_mult_top #(
   parameter int MAX_TERMS = pasm_pkg::MAX_TERMS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [15:0] coef_in, [17:16] op
   input  wire logic [1:0]  req_tuser,   // [1:0] action
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] coef_out, [36:32] power
   output logic [1:0]       rsp_tuser,   // [0] saturated, [1] terms_dropped
   output logic             rsp_tlast
);

   localparam int AW  = $clog2(MAX_TERMS);
   localparam int CW  = $clog2(MAX_TERMS + 1);
   localparam int NW  = pasm_pkg::N_W;
   localparam int KW  = pasm_pkg::POWER_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;

   logic [CW-1:0] ca_ff, ca_in;
   logic [CW-1:0] cb_ff, cb_in;
   logic          loading_a_ff, loading_a_in;
   logic          loading_b_ff, loading_b_in;
   logic          zero_a_ff, zero_a_in;
   logic          zero_b_ff, zero_b_in;
   logic          ovf_ff, ovf_in;

   logic          mul_ff, mul_in;
   logic          sub_ff, sub_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] klast_ff, klast_in;
   logic [AW-1:0] i_ff, i_in;
   logic          new_k_ff, new_k_in;

   logic [1:0]                          action;
   logic [1:0]                          op;
   logic [pasm_pkg::COEF_IN_W-1:0]      coef;
   logic                                accept;

   logic          we_a, we_b;
   logic [AW-1:0] waddr_a, waddr_b;
   logic [AW-1:0] raddr_a, raddr_b;
   logic signed [pasm_pkg::COEF_IN_W-1:0] rd_a, rd_b;

   logic [NW-1:0] ca7, cb7, k7, i7, j7, lo7, hi7, cam1, n7;
   logic [AW-1:0] i_cur;
   logic          term_last;
   logic          tail;
   logic          issue;
   logic          credit_ok;
   pasm_pkg::tag_type iss_tag;

   logic              out_valid;
   pasm_pkg::rsp_type out_word;

   assign action     = req_tuser;
   assign op         = req_tdata[17:16];
   assign coef       = req_tdata[15:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // term window of power k
   always_comb begin
      ca7   = {{(NW-CW){1'b0}}, ca_ff};
      cb7   = {{(NW-CW){1'b0}}, cb_ff};
      k7    = {{(NW-KW){1'b0}}, k_ff};
      lo7   = (k7 >= cb7) ? (k7 - cb7 + NW'(1)) : '0;
      cam1  = ca7 - NW'(1);
      hi7   = (cam1 < k7) ? cam1 : k7;
      i_cur = new_k_ff ? lo7[AW-1:0] : i_ff;
      i7    = {{(NW-AW){1'b0}}, i_cur};
      j7    = k7 - i7;
      term_last = mul_ff ? (i7 == hi7) : 1'b1;
      tail      = term_last && (k_ff == klast_ff);
      issue     = (state_ff == ST_RUN) && (!term_last || credit_ok);
      raddr_a   = mul_ff ? i_cur : k_ff[AW-1:0];
      raddr_b   = mul_ff ? j7[AW-1:0] : k_ff[AW-1:0];

      iss_tag.mul     = mul_ff;
      iss_tag.sub     = sub_ff;
      iss_tag.use_a   = !zero_a_ff && (mul_ff || (k7 < ca7));
      iss_tag.use_b   = !zero_b_ff && (mul_ff || (k7 < cb7));
      iss_tag.first   = new_k_ff;
      iss_tag.last    = term_last;
      iss_tag.tail    = tail;
      iss_tag.power   = k_ff;
      iss_tag.dropped = ovf_ff;
   end

   always_comb begin
      state_in     = state_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      loading_a_in = loading_a_ff;
      loading_b_in = loading_b_ff;
      zero_a_in    = zero_a_ff;
      zero_b_in    = zero_b_ff;
      ovf_in       = ovf_ff;
      mul_in       = mul_ff;
      sub_in       = sub_ff;
      k_in         = k_ff;
      klast_in     = klast_ff;
      i_in         = i_ff;
      new_k_in     = new_k_ff;
      we_a         = 1'b0;
      we_b         = 1'b0;
      waddr_a      = '0;
      waddr_b      = '0;
      n7           = '0;

      if (accept) begin
         unique case (action)
            pasm_pkg::ACT_LOAD_A: begin
               // a load word on a closed operand starts it over
               if (!loading_a_ff) begin
                  we_a      = 1'b1;
                  ca_in     = CW'(1);
                  zero_a_in = 1'b0;
               end else if (ca_ff < CW'(MAX_TERMS)) begin
                  we_a    = 1'b1;
                  waddr_a = ca_ff[AW-1:0];
                  ca_in   = ca_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               loading_a_in = !req_tlast;
            end
            pasm_pkg::ACT_LOAD_B: begin
               if (!loading_b_ff) begin
                  we_b      = 1'b1;
                  cb_in     = CW'(1);
                  zero_b_in = 1'b0;
               end else if (cb_ff < CW'(MAX_TERMS)) begin
                  we_b    = 1'b1;
                  waddr_b = cb_ff[AW-1:0];
                  cb_in   = cb_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               loading_b_in = !req_tlast;
            end
            pasm_pkg::ACT_RUN: begin
               if (op == pasm_pkg::OP_ADD || op == pasm_pkg::OP_SUB ||
                   op == pasm_pkg::OP_MUL) begin
                  if (op == pasm_pkg::OP_MUL) begin
                     n7 = ca7 + cb7 - NW'(1);
                  end else begin
                     n7 = (ca7 > cb7) ? ca7 : cb7;
                  end
                  if (n7 > NW'(pasm_pkg::POW_LIMIT)) begin
                     n7 = NW'(pasm_pkg::POW_LIMIT);
                  end
                  klast_in     = KW'(n7 - NW'(1));
                  mul_in       = (op == pasm_pkg::OP_MUL);
                  sub_in       = (op == pasm_pkg::OP_SUB);
                  k_in         = '0;
                  new_k_in     = 1'b1;
                  loading_a_in = 1'b0;
                  loading_b_in = 1'b0;
                  state_in     = ST_RUN;
               end
            end
            default: begin
            end
         endcase
      end

      if (issue) begin
         if (term_last) begin
            new_k_in = 1'b1;
            if (tail) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end else begin
            i_in     = i_cur + AW'(1);
            new_k_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ca_ff        <= CW'(1);
         cb_ff        <= CW'(1);
         loading_a_ff <= 1'b0;
         loading_b_ff <= 1'b0;
         zero_a_ff    <= 1'b1;
         zero_b_ff    <= 1'b1;
         ovf_ff       <= 1'b0;
         new_k_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         ca_ff        <= ca_in;
         cb_ff        <= cb_in;
         loading_a_ff <= loading_a_in;
         loading_b_ff <= loading_b_in;
         zero_a_ff    <= zero_a_in;
         zero_b_ff    <= zero_b_in;
         ovf_ff       <= ovf_in;
         new_k_ff     <= new_k_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff   <= mul_in;
      sub_ff   <= sub_in;
      k_ff     <= k_in;
      klast_ff <= klast_in;
      i_ff     <= i_in;
   end

   pasm_ram #(
      .WIDTH (pasm_pkg::COEF_IN_W),
      .DEPTH (MAX_TERMS)
   ) u_ram_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr_a),
      .wdata (coef),
      .raddr (raddr_a),
      .rdata (rd_a)
   );

   pasm_ram #(
      .WIDTH (pasm_pkg::COEF_IN_W),
      .DEPTH (MAX_TERMS)
   ) u_ram_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr_b),
      .wdata (coef),
      .raddr (raddr_b),
      .rdata (rd_b)
   );

   pasm_mac #(
      .MAX_TERMS (MAX_TERMS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .iss_valid (issue),
      .iss_tag   (iss_tag),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .credit_ok (credit_ok),
      .out_valid (out_valid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {3'b000, out_word.power, out_word.coef};
   assign rsp_tuser  = {out_word.dropped, out_word.sat};
   assign rsp_tlast  = out_word.last;

`ifndef NO_ASSERTIONS
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (we_a || we_b) |-> (state_ff == ST_IDLE))
      else $error("operand written during a run");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ca_ff != '0) && (cb_ff != '0))
      else $error("operand count dropped to zero");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && !issue) |=> ($stable(k_ff) && $stable(new_k_ff)))
      else $error("sequencer advanced while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/pasm_ram.sv
`default_nettype none

module pasm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// File: rtl/pasm_mac.sv
`default_nettype none

module pasm_mac #(
   parameter int MAX_TERMS = pasm_pkg::MAX_TERMS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  iss_valid,
   input  wire pasm_pkg::tag_type                     iss_tag,
   input  wire logic signed [pasm_pkg::COEF_IN_W-1:0] rd_a,
   input  wire logic signed [pasm_pkg::COEF_IN_W-1:0] rd_b,
   output logic                                       credit_ok,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output pasm_pkg::rsp_type                          out_word
);

   localparam int ACC_W = pasm_pkg::COEF_OUT_W + $clog2(MAX_TERMS) + 1;

   // stage 1: memory data arrives with the tag
   logic              s1_valid_ff;
   pasm_pkg::tag_type s1_tag_ff;

   // stage 2: product or scaled sum
   logic                                  s2_valid_ff;
   pasm_pkg::tag_type                     s2_tag_ff;
   logic signed [pasm_pkg::COEF_OUT_W-1:0] s2_term_ff;
   logic signed [pasm_pkg::COEF_OUT_W-1:0] s2_term_in;

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_sum;

   logic signed [pasm_pkg::COEF_IN_W-1:0]  a_val;
   logic signed [pasm_pkg::COEF_IN_W-1:0]  b_val;
   logic signed [pasm_pkg::COEF_IN_W:0]    sum17;
   logic signed [pasm_pkg::COEF_OUT_W-1:0] prod;

   logic [ACC_W-32:0] upper;
   logic              sat;
   pasm_pkg::rsp_type push_word;
   logic              push;
   logic              pop;

   pasm_pkg::rsp_type            fifo_ff [pasm_pkg::OUT_DEPTH];
   logic [pasm_pkg::OPTR_W-1:0]  wptr_ff, wptr_in;
   logic [pasm_pkg::OPTR_W-1:0]  rptr_ff, rptr_in;
   logic [pasm_pkg::OCNT_W-1:0]  fcnt_ff, fcnt_in;
   logic [pasm_pkg::OCNT_W-1:0]  cred_ff, cred_in;
   logic                         cred_inc;

   always_comb begin
      a_val = s1_tag_ff.use_a ? rd_a : '0;
      b_val = s1_tag_ff.use_b ? rd_b : '0;
      sum17 = s1_tag_ff.sub ? ({a_val[15], a_val} - {b_val[15], b_val})
                            : ({a_val[15], a_val} + {b_val[15], b_val});
      prod  = pasm_pkg::COEF_OUT_W'(a_val) * pasm_pkg::COEF_OUT_W'(b_val);
      if (s1_tag_ff.mul) begin
         s2_term_in = prod;
      end else begin
         // Q8.8 to Q16.16
         s2_term_in = {{7{sum17[16]}}, sum17, 8'h00};
      end
   end

   always_comb begin
      acc_sum = (s2_tag_ff.first ? '0 : acc_ff)
              + {{(ACC_W-pasm_pkg::COEF_OUT_W){s2_term_ff[31]}}, s2_term_ff};
      upper   = acc_sum[ACC_W-1:31];
      sat     = !((&upper) || (~|upper));
      push_word.dropped = s2_tag_ff.dropped;
      push_word.sat     = sat;
      push_word.last    = s2_tag_ff.tail;
      push_word.power   = s2_tag_ff.power;
      if (sat) begin
         push_word.coef = acc_sum[ACC_W-1] ? pasm_pkg::COEF_MIN : pasm_pkg::COEF_MAX;
      end else begin
         push_word.coef = acc_sum[31:0];
      end
      push = s2_valid_ff && s2_tag_ff.last;
   end

   always_comb begin
      out_valid = (fcnt_ff != '0);
      out_word  = fifo_ff[rptr_ff];
      pop       = out_valid && out_ready;
      wptr_in   = push ? wptr_ff + pasm_pkg::OPTR_W'(1) : wptr_ff;
      rptr_in   = pop ? rptr_ff + pasm_pkg::OPTR_W'(1) : rptr_ff;
      fcnt_in   = fcnt_ff + {2'b00, push} - {2'b00, pop};
      // one credit per coefficient issued and not yet taken
      cred_inc  = iss_valid && iss_tag.last;
      cred_in   = cred_ff + {2'b00, cred_inc} - {2'b00, pop};
      credit_ok = (cred_ff != pasm_pkg::OCNT_W'(pasm_pkg::OUT_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wptr_ff     <= '0;
         rptr_ff     <= '0;
         fcnt_ff     <= '0;
         cred_ff     <= '0;
      end else begin
         s1_valid_ff <= iss_valid;
         s2_valid_ff <= s1_valid_ff;
         wptr_ff     <= wptr_in;
         rptr_ff     <= rptr_in;
         fcnt_ff     <= fcnt_in;
         cred_ff     <= cred_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff  <= iss_tag;
      s2_tag_ff  <= s1_tag_ff;
      s2_term_ff <= s2_term_in;
      if (s2_valid_ff) begin
         acc_ff <= acc_sum;
      end
      if (push) begin
         fifo_ff[wptr_ff] <= push_word;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (fcnt_ff != pasm_pkg::OCNT_W'(pasm_pkg::OUT_DEPTH)))
      else $error("result pushed into full buffer");

   a_credit_cover: assert property (@(posedge clock) disable iff (reset)
      cred_ff >= fcnt_ff)
      else $error("buffered results exceed issued credits");

   a_credit_gate: assert property (@(posedge clock) disable iff (reset)
      cred_inc |-> credit_ok)
      else $error("coefficient issued without a free credit");
`endif

endmodule

`default_nettype wire
